### hdl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the MurmurHash2 Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  localparam int unsigned DEF_BITMAP_BITS = 65536;
  localparam int unsigned DEF_MAX_HASHES  = 4;
  localparam int unsigned DEF_MAX_KEY_LEN = 256;

  localparam int unsigned SEED_REGS = 4;
  localparam int unsigned LANE_CW   = 4;   // lane counter width, holds up to SEED_REGS
  localparam logic [31:0] MUR_M     = 32'h5bd1e995;

  // opcodes and result kinds share codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_BIT_COUNT  = 3'd0;
  localparam logic [2:0] REG_HASH_COUNT = 3'd1;
  localparam logic [2:0] REG_SEED0      = 3'd2;
  localparam logic [2:0] REG_SEED1      = 3'd3;
  localparam logic [2:0] REG_SEED2      = 3'd4;
  localparam logic [2:0] REG_SEED3      = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MIX0,
    S_MIX1,
    S_MIXL,
    S_F0,
    S_F1,
    S_F2,
    S_DIV,
    S_RD,
    S_WR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### hdl/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### hdl/bloom_filter_murmur2.sv
// Flow: a key byte is taken in S_IDLE; a byte that completes a 4-byte word is then
//   mixed on the shared multiplier in S_MIX0, S_MIX1 and one S_MIXL step per lane.
// Key end: per applied hash, after the last byte (and any word mixing): 3 finish
//   steps, 32-step modulo, bitmap read, write; the result is registered once the output is free.
// Clear and reset sweep the bitmap one row per cycle over all ROWS (2048) rows; one
//   transaction in flight at a time. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// bloom_filter_murmur2
// Bloom filter over byte keys with seeded MurmurHash2, bitmap held in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_murmur2
  import bfm_pkg::*;
#(
  parameter int unsigned BITMAP_BITS = DEF_BITMAP_BITS,
  parameter int unsigned MAX_HASHES  = DEF_MAX_HASHES,
  parameter int unsigned MAX_KEY_LEN = DEF_MAX_KEY_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // key_byte[7:0], key_length[16:8], zero pad
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // element_count[31:0]
  output logic      [2:0]  out_tuser,  // result_kind[1:0], found[2]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int unsigned LANES = (MAX_HASHES < SEED_REGS) ? MAX_HASHES : SEED_REGS;
  localparam int unsigned LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned IDX_W = $clog2(BITMAP_BITS);
  localparam int unsigned ROW_W = IDX_W - 5;
  localparam int unsigned ROWS  = (BITMAP_BITS + 31) / 32;
  localparam int unsigned MW    = $clog2(BITMAP_BITS + 1);
  localparam int unsigned DW    = MW + 1;
  localparam int unsigned PW    = $clog2(MAX_KEY_LEN + 1);

  // configuration
  logic [16:0] bit_count_r;
  logic [2:0]  hash_count_r;
  logic [31:0] seed_r [SEED_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= 17'd65536;
      hash_count_r <= 3'd4;
      for (int i = 0; i < SEED_REGS; i++) begin
        seed_r[i] <= 32'(i);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_COUNT:  bit_count_r  <= cfg_wdata[16:0];
        REG_HASH_COUNT: hash_count_r <= cfg_wdata[2:0];
        REG_SEED0:      seed_r[0]    <= cfg_wdata;
        REG_SEED1:      seed_r[1]    <= cfg_wdata;
        REG_SEED2:      seed_r[2]    <= cfg_wdata;
        REG_SEED3:      seed_r[3]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective modulus and hash count
  logic [31:0]      bc_ext;
  logic [MW-1:0]    m_eff;
  logic [LANE_CW-1:0] k_eff;

  always_comb begin
    bc_ext = {15'd0, bit_count_r};
    if (bc_ext == 32'd0) begin
      m_eff = MW'(1);
    end else if (bc_ext > 32'(BITMAP_BITS)) begin
      m_eff = MW'(BITMAP_BITS);
    end else begin
      m_eff = bc_ext[MW-1:0];
    end
    if ({1'b0, hash_count_r} > LANE_CW'(LANES)) begin
      k_eff = LANE_CW'(LANES);
    end else begin
      k_eff = {1'b0, hash_count_r};
    end
  end

  // state
  state_t             state_r, state_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [23:0]        pw_r, pw_nxt;
  logic [31:0]        cnt_r, cnt_nxt;
  logic [31:0]        hash_r [LANES];
  logic [31:0]        hash_nxt [LANES];
  logic [31:0]        t_r, t_nxt;
  logic [1:0]         op_r, op_nxt;
  logic               last_r, last_nxt;
  logic               hit_r, hit_nxt;
  logic [LANE_CW-1:0] lane_r, lane_nxt;
  logic [4:0]         div_cnt_r, div_cnt_nxt;
  logic [31:0]        div_q_r, div_q_nxt;
  logic [DW-1:0]      div_rem_r, div_rem_nxt;
  logic [ROW_W-1:0]   sweep_r, sweep_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [31:0]        out_tdata_r, out_tdata_nxt;
  logic [2:0]         out_tuser_r, out_tuser_nxt;

  // input fields
  logic [7:0] key_byte;
  logic [8:0] key_length;
  assign key_byte   = in_tdata[7:0];
  assign key_length = in_tdata[16:8];

  // shared multiplier, low 32 bits of the product
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] cur_hash;

  assign cur_hash = hash_r[lane_r[LW-1:0]];
  assign prod     = mul_a * MUR_M;

  always_comb begin
    case (state_r)
      S_MIX0:  mul_a = t_r;
      S_MIX1:  mul_a = t_r ^ (t_r >> 24);
      S_MIXL:  mul_a = cur_hash;
      S_F0:    mul_a = cur_hash ^ {8'd0, pw_r};
      S_F1:    mul_a = t_r ^ (t_r >> 13);
      default: mul_a = 32'd0;
    endcase
  end

  // bitmap RAM
  logic             ram_we;
  logic [ROW_W-1:0] ram_addr;
  logic [31:0]      ram_wdata;
  logic [31:0]      ram_rdata;
  logic [31:0]      bit_mask;

  assign bit_mask = 32'd1 << div_rem_r[4:0];

  bfm_ram #(
    .WIDTH(32),
    .DEPTH(ROWS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  logic          out_free;
  logic          in_acc;
  logic          do_byte;
  logic [1:0]    slot;
  logic [DW-1:0] trial;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign do_byte   = (key_length != 9'd0) && (32'(pos_r) < 32'(MAX_KEY_LEN));
  assign slot      = pos_r[1:0];
  assign trial     = {div_rem_r[DW-2:0], div_q_r[31]};

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    pw_nxt         = pw_r;
    cnt_nxt        = cnt_r;
    for (int i = 0; i < LANES; i++) begin
      hash_nxt[i] = hash_r[i];
    end
    t_nxt          = t_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    hit_nxt        = hit_r;
    lane_nxt       = lane_r;
    div_cnt_nxt    = div_cnt_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    sweep_nxt      = sweep_r;
    clr_resp_nxt   = clr_resp_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_addr       = div_rem_r[IDX_W-1:5];
    ram_wdata      = ram_rdata | bit_mask;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_r;
        ram_wdata = 32'd0;
        sweep_nxt = sweep_r + ROW_W'(1);
        if (32'(sweep_r) == ROWS - 1) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_CLEAR) begin
            pos_nxt      = '0;
            pw_nxt       = '0;
            cnt_nxt      = '0;
            sweep_nxt    = '0;
            clr_resp_nxt = 1'b1;
            op_nxt       = OP_CLEAR;
            state_nxt    = S_CLEAR;
          end else if (in_tuser != OP_NONE) begin
            op_nxt   = in_tuser;
            last_nxt = in_tlast;
            lane_nxt = '0;
            hit_nxt  = 1'b1;
            if (pos_r == '0 && (do_byte || in_tlast)) begin
              for (int i = 0; i < LANES; i++) begin
                hash_nxt[i] = seed_r[i] ^ {23'd0, key_length};
              end
            end
            if (in_tlast) begin
              state_nxt = (k_eff == '0) ? S_RESP : S_F0;
            end
            if (do_byte) begin
              pos_nxt = pos_r + PW'(1);
              case (slot)
                2'd0: pw_nxt = {pw_r[23:8], key_byte};
                2'd1: pw_nxt = {pw_r[23:16], key_byte, pw_r[7:0]};
                2'd2: pw_nxt = {key_byte, pw_r[15:0]};
                default: begin
                  t_nxt     = {key_byte, pw_r};
                  pw_nxt    = '0;
                  state_nxt = S_MIX0;
                end
              endcase
            end
          end
        end
      end
      S_MIX0: begin
        t_nxt     = prod;
        state_nxt = S_MIX1;
      end
      S_MIX1: begin
        t_nxt     = prod;
        lane_nxt  = '0;
        state_nxt = S_MIXL;
      end
      S_MIXL: begin
        hash_nxt[lane_r[LW-1:0]] = prod ^ t_r;
        lane_nxt = lane_r + LANE_CW'(1);
        if (32'(lane_r) == LANES - 1) begin
          lane_nxt = '0;
          if (last_r) begin
            state_nxt = (k_eff == '0) ? S_RESP : S_F0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_F0: begin
        t_nxt     = (pos_r[1:0] != 2'd0) ? prod : (cur_hash ^ {8'd0, pw_r});
        state_nxt = S_F1;
      end
      S_F1: begin
        t_nxt     = prod;
        state_nxt = S_F2;
      end
      S_F2: begin
        div_q_nxt   = t_r ^ (t_r >> 15);
        div_rem_nxt = '0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, m_eff}) begin
          div_rem_nxt = trial - {1'b0, m_eff};
        end else begin
          div_rem_nxt = trial;
        end
        div_q_nxt   = {div_q_r[30:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (op_r == OP_ADD) begin
          ram_we = 1'b1;
        end else if ((ram_rdata & bit_mask) == 32'd0) begin
          hit_nxt = 1'b0;
        end
        lane_nxt = lane_r + LANE_CW'(1);
        if (lane_r + LANE_CW'(1) == k_eff) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_F0;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          clr_resp_nxt   = 1'b0;
          pos_nxt        = '0;
          pw_nxt         = '0;
          case (op_r)
            OP_ADD: begin
              cnt_nxt       = cnt_r + 32'd1;
              out_tdata_nxt = cnt_r + 32'd1;
              out_tuser_nxt = {1'b0, OP_ADD};
            end
            OP_QUERY: begin
              out_tdata_nxt = cnt_r;
              out_tuser_nxt = {hit_r, OP_QUERY};
            end
            default: begin
              out_tdata_nxt = 32'd0;
              out_tuser_nxt = {1'b0, OP_CLEAR};
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pos_r        <= '0;
      pw_r         <= '0;
      cnt_r        <= '0;
      for (int i = 0; i < LANES; i++) begin
        hash_r[i] <= '0;
      end
      lane_r       <= '0;
      sweep_r      <= '0;
      clr_resp_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      pw_r         <= pw_nxt;
      cnt_r        <= cnt_nxt;
      for (int i = 0; i < LANES; i++) begin
        hash_r[i] <= hash_nxt[i];
      end
      lane_r       <= lane_nxt;
      sweep_r      <= sweep_nxt;
      clr_resp_r   <= clr_resp_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    hit_r       <= hit_nxt;
    div_cnt_r   <= div_cnt_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

### hdl/bfm_chk.sv
// ----------------------------------------------------------------------------
// bfm_chk
// Port-level checks of the Bloom filter result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_chk
  import bfm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // a stalled transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != OP_NONE)
    else $error("unused result kind");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == OP_CLEAR |-> out_tdata == 32'd0 && !out_tuser[2])
    else $error("clear result not empty");

  a_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == OP_ADD |-> !out_tuser[2] && out_tdata != 32'd0 ||
      out_tvalid && out_tuser[1:0] == OP_ADD && !out_tuser[2] && out_tdata == 32'd0)
    else $error("add result carries found");

endmodule

bind bloom_filter_murmur2 bfm_chk u_bfm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

### sim/bfm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfm_checker
// Watches the key and result streams of the Bloom filter, predicts each
// result from its own MurmurHash2 and bitmap copy, and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_checker
  import bfm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);

  typedef struct packed {
    logic [1:0]  kind;
    logic        found;
    logic [31:0] count;
  } filter_result_t;

  filter_result_t expected_q[$];

  logic [16:0] m_bits;
  logic [2:0]  m_hashes;
  logic [31:0] m_seed [SEED_REGS];
  bit          m_bitmap [DEF_BITMAP_BITS];
  logic [31:0] m_lane [SEED_REGS];
  logic [31:0] m_partial;
  int unsigned m_pos;
  logic [31:0] m_added;

  assign pending = expected_q.size();

  function automatic logic [31:0] murmur_final(logic [31:0] h, int unsigned rem);
    h ^= m_partial;
    if (rem != 0) h *= MUR_M;
    h ^= h >> 13;
    h *= MUR_M;
    h ^= h >> 15;
    return h;
  endfunction

  task automatic filter_step(logic [1:0] op, logic [7:0] kb, logic [8:0] klen,
                             logic last);
    filter_result_t r;
    logic [31:0] w, idx, mod;
    int unsigned k, rem;
    bit hit;
    hit = 1;
    if (op == OP_NONE) return;
    if (op == OP_CLEAR) begin
      foreach (m_bitmap[i]) m_bitmap[i] = 0;
      m_added = 0; m_partial = 0; m_pos = 0;
      r = '{kind: OP_CLEAR, found: 1'b0, count: 32'd0};
      expected_q.insert(expected_q.size(), r);
      return;
    end
    if (klen != 0 && m_pos < DEF_MAX_KEY_LEN) begin
      if (m_pos == 0)
        for (int i = 0; i < SEED_REGS; i++) m_lane[i] = m_seed[i] ^ klen;
      if ((m_pos & 3) == 3) begin
        w = m_partial | (32'(kb) << 24);
        w *= MUR_M;
        w ^= w >> 24;
        w *= MUR_M;
        for (int i = 0; i < SEED_REGS; i++) m_lane[i] = (m_lane[i] * MUR_M) ^ w;
        m_partial = 0;
      end else begin
        m_partial |= 32'(kb) << (8 * (m_pos & 3));
      end
      m_pos++;
    end
    if (!last) return;
    if (m_pos == 0)
      for (int i = 0; i < SEED_REGS; i++) m_lane[i] = m_seed[i] ^ klen;
    rem = m_pos & 3;
    mod = (m_bits == 0) ? 1 : (m_bits > DEF_BITMAP_BITS) ? DEF_BITMAP_BITS : m_bits;
    k = (m_hashes > SEED_REGS) ? SEED_REGS : m_hashes;
    for (int i = 0; i < k; i++) begin
      idx = murmur_final(m_lane[i], rem) % mod;
      if (op == OP_ADD) m_bitmap[idx] = 1;
      else if (!m_bitmap[idx]) hit = 0;
    end
    m_partial = 0; m_pos = 0;
    if (op == OP_ADD) begin
      m_added++;
      r = '{kind: OP_ADD, found: 1'b0, count: m_added};
    end else begin
      r = '{kind: OP_QUERY, found: hit, count: m_added};
    end
    expected_q.insert(expected_q.size(), r);
  endtask

  always @(posedge clk) begin
    filter_result_t e;
    if (!rst_n) begin
      m_bits <= 17'd65536; m_hashes <= 3'd4;
      for (int i = 0; i < SEED_REGS; i++) m_seed[i] <= i;
      foreach (m_bitmap[i]) m_bitmap[i] = 0;
      m_partial = 0; m_pos = 0; m_added = 0;
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we)
        case (cfg_index)
          REG_BIT_COUNT:  m_bits <= cfg_wdata[16:0];
          REG_HASH_COUNT: m_hashes <= cfg_wdata[2:0];
          REG_SEED0:      m_seed[0] <= cfg_wdata;
          REG_SEED1:      m_seed[1] <= cfg_wdata;
          REG_SEED2:      m_seed[2] <= cfg_wdata;
          REG_SEED3:      m_seed[3] <= cfg_wdata;
          default: ;
        endcase
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result tuser=%h tdata=%h",
                                        out_tuser, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_tuser[1:0] !== e.kind || out_tuser[2] !== e.found ||
              out_tdata !== e.count) begin
            if (fail_count < 10)
              $display("mismatch: exp kind=%0d found=%0d count=%0d, got %0d %0d %0d",
                       e.kind, e.found, e.count, out_tuser[1:0], out_tuser[2], out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      // predict after the result check so a same-cycle new entry is not popped
      if (in_tvalid && in_tready)
        filter_step(in_tuser, in_tdata[7:0], in_tdata[16:8], in_tlast);
    end
  end

endmodule

`default_nettype wire

### sim/tb_bloom_filter_murmur2.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_murmur2
// Drives add, query and clear transactions into the Bloom filter under
// several register settings and random stalls; the checker judges results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bloom_filter_murmur2
  import bfm_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          results_seen;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  int  idle_cycles;
  int  keys_sent;

  // remembered keys so queries hit as well as miss
  byte key_mem [8][$];

  bloom_filter_murmur2 u_top (.*);

  bfm_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall, or long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // tvalid stays high between back-to-back transactions unless a random idle gap drops it
  task automatic send_item(logic [1:0] op, logic [7:0] kb, logic [8:0] klen,
                           logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {7'd0, klen, kb};
    in_tuser  <= op;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_stop();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic send_key(logic [1:0] op, byte kbytes[$]);
    int n;
    n = kbytes.size();
    if (n == 0) send_item(op, 8'($urandom), 9'd0, 1'b1);
    else
      for (int i = 0; i < n; i++)
        send_item(op, kbytes[i], (n > 256) ? 9'd256 : 9'(n), i == n - 1);
    keys_sent++;
  endtask

  task automatic wait_drained();
    send_stop();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic random_key(output byte kb[$]);
    int n;
    kb = {};
    n = $urandom_range(12);
    repeat (n) kb = {kb, byte'($urandom)};
  endtask

  task automatic random_phase(int count);
    byte kb[$];
    int slot, r;
    repeat (count) begin
      r = $urandom_range(99);
      slot = $urandom_range(7);
      if (r < 40) begin
        random_key(kb);
        key_mem[slot] = kb;
        send_key(OP_ADD, kb);
      end else if (r < 60) begin
        send_key(OP_QUERY, key_mem[slot]);
      end else if (r < 80) begin
        random_key(kb);
        send_key(OP_QUERY, kb);
      end else if (r < 83) begin
        send_item(OP_CLEAR, 8'($urandom), 9'($urandom), 1'($urandom));
      end else if (r < 88) begin
        send_item(OP_NONE, 8'($urandom), 9'($urandom), 1'($urandom));
      end else if (r < 92) begin
        send_item(2'($urandom_range(1)), 8'($urandom), 9'd0, 1'b0);
      end else begin
        // length mismatch or mixed opcodes inside one key
        kb = {};
        repeat ($urandom_range(1, 9)) kb = {kb, byte'($urandom)};
        for (int i = 0; i < kb.size(); i++)
          send_item(2'($urandom_range(1)), kb[i], 9'($urandom_range(1, 511)),
                    i == kb.size() - 1);
      end
    end
    send_stop();
  endtask

  initial begin
    byte kb[$];
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0; in_tlast = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0; keys_sent = 0;
    foreach (key_mem[i]) key_mem[i] = {};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults, empty key, every tail length, extremes
    send_key(OP_ADD, kb);
    send_key(OP_QUERY, kb);
    for (int n = 1; n <= 5; n++) begin
      kb = {kb, byte'(8'hff)};
      send_key(OP_ADD, kb);
      send_key(OP_QUERY, kb);
    end
    send_item(OP_ADD, 8'h00, 9'd0, 1'b0);
    send_item(OP_NONE, 8'hff, 9'h1ff, 1'b1);
    send_item(OP_ADD, 8'h5a, 9'd7, 1'b0);
    send_item(OP_CLEAR, 8'hff, 9'h1ff, 1'b0);
    send_key(OP_QUERY, kb);
    kb = {};
    repeat (257) kb = {kb, byte'($urandom)};
    send_key(OP_ADD, kb);
    send_key(OP_QUERY, kb);
    send_item(OP_CLEAR, 8'h00, 9'd0, 1'b1);
    wait_drained();

    // phase settings: bit_count, hash_count, seeds
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 12; recv_idle_pct = 55; end
        2: begin send_idle_pct = 55; recv_idle_pct = 12; end
        4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        default: ;
      endcase
      case (ph)
        0: write_reg(REG_BIT_COUNT, 32'd64);
        1: write_reg(REG_BIT_COUNT, 32'd1);
        2: write_reg(REG_BIT_COUNT, 32'd0);
        3: write_reg(REG_BIT_COUNT, 32'h1ffff);
        4: write_reg(REG_BIT_COUNT, 32'd65536);
        default: write_reg(REG_BIT_COUNT, $urandom_range(2, 3000));
      endcase
      write_reg(REG_HASH_COUNT, (ph == 1) ? 32'd0 : (ph == 3) ? 32'd7 : $urandom_range(1, 4));
      write_reg(REG_SEED0, (ph == 0) ? 32'hffffffff : $urandom);
      write_reg(REG_SEED1, (ph == 0) ? 32'h0 : $urandom);
      write_reg(REG_SEED2, $urandom);
      write_reg(REG_SEED3, $urandom);
      cfg_we <= 0;
      if (ph == 2) begin
        // long receiver hold-off while keys keep coming
        hold_off <= 1;
        fork
          begin repeat (3000) @(posedge clk); hold_off <= 0; end
          random_phase(6);
        join
      end
      random_phase(ph == 1 ? 4 : 7);
      wait_drained();
    end

    $display("covered %0d keys and %0d results over six register settings,",
             keys_sent, results_seen);
    $display("including empty, long and mismatched keys, clears and stalls");
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
